// File: hdl/rts_pkg.sv
`default_nettype none

package rts_pkg;

   localparam int TASK_COUNT = 8;
   localparam int TICK_SHIFT = 5;
   localparam int IDX_W      = (TASK_COUNT > 1) ? $clog2(TASK_COUNT) : 1;

   localparam logic [30:0] HORIZON_RESET = 31'd60000;

   localparam logic CMD_SCHEDULE = 1'b0;
   localparam logic CMD_WRITE    = 1'b1;

   typedef logic [IDX_W-1:0] idx_type;

   typedef struct packed {
      logic [7:0]         code;
      logic [7:0]         reserve;
      logic [7:0]         latency;
      logic signed [31:0] remaining;
   } entry_type;

   typedef struct packed {
      logic    start;
      logic    age;
      logic    pick;
      idx_type idx;
   } scan_ctrl_type;

   typedef struct packed {
      logic               found;
      idx_type            idx;
      logic signed [31:0] next_time;
   } pick_type;

   function automatic logic signed [31:0] sat33(input logic signed [32:0] s);
      logic signed [31:0] r;
      if (s[32] != s[31]) begin
         r = s[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
      end else begin
         r = s[31:0];
      end
      return r;
   endfunction

endpackage

`default_nettype wire

// File: hdl/rts_cell.sv
`default_nettype none

module rts_cell (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              shift_en,
   input  wire logic              load_en,
   input  wire rts_pkg::entry_type shift_in,
   input  wire rts_pkg::entry_type load_data,
   output      rts_pkg::entry_type entry
);
   import rts_pkg::*;

   entry_type entry_ff;
   entry_type entry_in;

   always_comb begin
      entry_in = entry_ff;
      if (load_en) begin
         entry_in = load_data;
      end else if (shift_en) begin
         entry_in = shift_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_ff <= '0;
      end else begin
         entry_ff <= entry_in;
      end
   end

   assign entry = entry_ff;

endmodule

`default_nettype wire

// File: hdl/rts_scan.sv
`default_nettype none

module rts_scan (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire rts_pkg::scan_ctrl_type ctrl,
   input  wire rts_pkg::entry_type    head,
   input  wire logic [15:0]          elapsed,
   input  wire logic [30:0]          horizon,
   output      rts_pkg::entry_type    aged,
   output      rts_pkg::pick_type     pick
);
   import rts_pkg::*;

   logic signed [31:0] next_ff;
   idx_type            sel_ff;
   logic [7:0]         res_ff;
   logic               found_ff;
   idx_type            pre_idx_ff;
   logic signed [31:0] pre_time_ff;
   logic               pre_found_ff;

   logic [15:0]        eff_elapsed;
   logic signed [31:0] aged_time;
   logic               active;
   logic [31:0]        res_clk;
   logic               preempts;

   assign eff_elapsed = ctrl.age ? elapsed : 16'd0;
   assign aged_time   = sat33(signed'({head.remaining[31], head.remaining})
                              - signed'({17'd0, eff_elapsed}));
   assign active      = (head.code != 8'd0);
   assign res_clk     = 32'(res_ff) << TICK_SHIFT;
   assign preempts    = found_ff && active && (ctrl.idx < sel_ff) &&
                        ((head.latency < res_ff) || (head.remaining < signed'(res_clk)));

   always_comb begin
      aged           = head;
      aged.remaining = aged_time;
   end

   // soonest-task scan, then preemption scan; last hit is the lowest index
   always_ff @(posedge clock) begin
      if (reset) begin
         found_ff     <= 1'b0;
         pre_found_ff <= 1'b0;
      end else if (ctrl.start) begin
         found_ff     <= 1'b0;
         pre_found_ff <= 1'b0;
      end else if (ctrl.age && active) begin
         if (aged_time <= next_ff) begin
            found_ff <= 1'b1;
         end else if (aged_time <= 32'sd0) begin
            found_ff <= 1'b1;
         end
      end else if (ctrl.pick && preempts) begin
         pre_found_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.start) begin
         next_ff <= signed'({1'b0, horizon});
      end else if (ctrl.age && active) begin
         if (aged_time <= next_ff) begin
            next_ff <= aged_time;
            sel_ff  <= ctrl.idx;
            res_ff  <= head.reserve;
         end else if (aged_time <= 32'sd0) begin
            sel_ff  <= ctrl.idx;
            res_ff  <= head.reserve;
         end
      end else if (ctrl.pick && preempts) begin
         pre_idx_ff  <= ctrl.idx;
         pre_time_ff <= head.remaining;
      end
   end

   always_comb begin
      pick.found     = found_ff;
      pick.idx       = pre_found_ff ? pre_idx_ff : sel_ff;
      pick.next_time = pre_found_ff ? pre_time_ff : next_ff;
   end

endmodule

`default_nettype wire

// File: hdl/reserving_task_scheduler_top.sv
// channel  | direction | handshake             | payload
// req      | in        | req_valid / req_ready | command, elapsed, slot, event_code,
//          |           |                       | reserve, latency, next_time
// rsp      | out       | rsp_valid / rsp_ready | selected_task, task_valid, time_to_next
// csr      | in        | csr_wr_en             | horizon_limit (31 bit)
//
// a write item gives no result
// a schedule item rotates the task ring twice, one task per cycle per pass,
// and its result is registered once the second pass ends and the rsp register is free
// no new item is taken while a pass runs; a result waiting on rsp_ready does not
// block req, but a second finished pass waits in done with req_ready low
// synchronous active-high reset empties the task table and sets horizon to 60000
`default_nettype none

module reserving_task_scheduler_top (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output      logic               req_ready,
   input  wire logic               req_command,
   input  wire logic [15:0]        req_elapsed,
   input  wire logic [2:0]         req_slot,
   input  wire logic [7:0]         req_event_code,
   input  wire logic [7:0]         req_reserve,
   input  wire logic [7:0]         req_latency,
   input  wire logic signed [31:0] req_next_time,
   output      logic               rsp_valid,
   input  wire logic               rsp_ready,
   output      logic [2:0]         rsp_selected_task,
   output      logic               rsp_task_valid,
   output      logic signed [31:0] rsp_time_to_next,
   input  wire logic               csr_wr_en,
   input  wire logic [30:0]        csr_wr_data
);
   import rts_pkg::*;

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_PASS1 = 2'd1;
   localparam logic [1:0] ST_PASS2 = 2'd2;
   localparam logic [1:0] ST_DONE  = 2'd3;

   localparam idx_type LAST_IDX = IDX_W'(TASK_COUNT - 1);

   logic [1:0]         state_ff, state_in;
   idx_type            count_ff, count_in;
   logic [15:0]        elapsed_ff;
   logic [30:0]        horizon_ff;
   logic               rsp_valid_ff;
   logic [2:0]         rsp_sel_ff;
   logic               rsp_found_ff;
   logic signed [31:0] rsp_time_ff;

   logic               req_xfer;
   logic               wr_en;
   logic               start;
   logic               shift_en;
   logic               out_load;
   entry_type          wr_entry;
   entry_type          cell_q [TASK_COUNT];
   entry_type          ring_in [TASK_COUNT];
   entry_type          aged;
   scan_ctrl_type      ctrl;
   pick_type           pick;

   assign req_ready = (state_ff == ST_IDLE);
   assign req_xfer  = req_valid && req_ready;
   assign wr_en     = req_xfer && (req_command == CMD_WRITE);
   assign start     = req_xfer && (req_command == CMD_SCHEDULE);
   assign shift_en  = (state_ff == ST_PASS1) || (state_ff == ST_PASS2);
   assign out_load  = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      wr_entry.code      = req_event_code;
      wr_entry.reserve   = req_reserve;
      wr_entry.latency   = req_latency;
      wr_entry.remaining = sat33(signed'({req_next_time[31], req_next_time})
                                 + signed'({17'd0, req_elapsed}));
   end

   // ring turns toward higher index; the last cell feeds the scan unit
   always_comb begin
      ring_in[0] = aged;
      for (int k = 1; k < TASK_COUNT; k++) begin
         ring_in[k] = cell_q[k-1];
      end
   end

   for (genvar k = 0; k < TASK_COUNT; k++) begin : g_cell
      rts_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .shift_en  (shift_en),
         .load_en   (wr_en && (32'(req_slot) == k)),
         .shift_in  (ring_in[k]),
         .load_data (wr_entry),
         .entry     (cell_q[k])
      );
   end

   always_comb begin
      ctrl.start = start;
      ctrl.age   = (state_ff == ST_PASS1);
      ctrl.pick  = (state_ff == ST_PASS2);
      ctrl.idx   = LAST_IDX - count_ff;
   end

   rts_scan u_scan (
      .clock   (clock),
      .reset   (reset),
      .ctrl    (ctrl),
      .head    (cell_q[TASK_COUNT-1]),
      .elapsed (elapsed_ff),
      .horizon (horizon_ff),
      .aged    (aged),
      .pick    (pick)
   );

   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in = ST_PASS1;
               count_in = '0;
            end
         end
         ST_PASS1: begin
            count_in = count_ff + 1'b1;
            if (count_ff == LAST_IDX) begin
               state_in = ST_PASS2;
               count_in = '0;
            end
         end
         ST_PASS2: begin
            count_in = count_ff + 1'b1;
            if (count_ff == LAST_IDX) begin
               state_in = ST_DONE;
               count_in = '0;
            end
         end
         ST_DONE: begin
            if (out_load) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
            count_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         horizon_ff   <= HORIZON_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         if (csr_wr_en) begin
            horizon_ff <= csr_wr_data;
         end
         if (out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         elapsed_ff <= req_elapsed;
      end
      if (out_load) begin
         rsp_sel_ff   <= pick.found ? 3'(pick.idx) : 3'd0;
         rsp_found_ff <= pick.found;
         rsp_time_ff  <= pick.next_time;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_selected_task = rsp_sel_ff;
   assign rsp_task_valid    = rsp_found_ff;
   assign rsp_time_to_next  = rsp_time_ff;

`ifndef ASSERT_OFF
   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == ST_DONE)
      else $error("result raised outside of done state");

   a_pass_handoff: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_PASS1 && count_ff == LAST_IDX) |=>
      (state_ff == ST_PASS2 && count_ff == '0))
      else $error("first pass did not hand off to second pass");

   a_no_task_sel: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_found_ff) |-> rsp_sel_ff == 3'd0)
      else $error("nonzero index without a selected task");

   a_no_write_in_pass: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> !wr_en)
      else $error("task write during a scheduling pass");
`endif

endmodule

`default_nettype wire

// File: tb/rts_pick_checker.sv
`timescale 1ns / 100ps

module rts_pick_checker
   import rts_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_ready,
   input  logic               req_command,
   input  logic [15:0]        req_elapsed,
   input  logic [2:0]         req_slot,
   input  logic [7:0]         req_event_code,
   input  logic [7:0]         req_reserve,
   input  logic [7:0]         req_latency,
   input  logic signed [31:0] req_next_time,
   input  logic               rsp_valid,
   input  logic               rsp_ready,
   input  logic [2:0]         rsp_selected_task,
   input  logic               rsp_task_valid,
   input  logic signed [31:0] rsp_time_to_next,
   input  logic               csr_wr_en,
   input  logic [30:0]        csr_wr_data,
   output int                 pending_picks,
   output int                 mismatch_count
);

   localparam longint TIME_MIN = -64'sd2147483648;
   localparam longint TIME_MAX = 64'sd2147483647;

   typedef struct packed {
      logic [2:0]         task_id;
      logic               found;
      logic signed [31:0] time_to_next;
   } pick_type;

   logic [30:0]        horizon;
   logic [7:0]         codes     [TASK_COUNT];
   logic [7:0]         reserves  [TASK_COUNT];
   logic [7:0]         latencies [TASK_COUNT];
   logic signed [31:0] time_left [TASK_COUNT];
   pick_type           pick_queue [$];
   int                 errors;

   function automatic logic signed [31:0] clamp_time(input longint v);
      if (v < TIME_MIN) return 32'sh8000_0000;
      if (v > TIME_MAX) return 32'sh7fff_ffff;
      return v[31:0];
   endfunction

   // ages the table, picks the soonest task, then applies preemption
   function automatic pick_type pick_next_task(input logic [15:0] elapsed);
      pick_type p;
      longint   best;
      longint   t;
      longint   res_clk;
      int       sel;
      best = longint'(horizon);
      sel  = -1;
      for (int i = TASK_COUNT - 1; i >= 0; i--) begin
         time_left[i] = clamp_time(longint'(time_left[i]) - longint'(elapsed));
         t = longint'(time_left[i]);
         if (codes[i] != 8'd0) begin
            if (t <= best) begin
               best = t;
               sel  = i;
            end else if (t <= 0) begin
               sel = i;
            end
         end
      end
      if (sel >= 0) begin
         res_clk = longint'(reserves[sel]) << TICK_SHIFT;
         for (int i = 0; i < sel; i++) begin
            if (codes[i] != 8'd0 &&
                (latencies[i] < reserves[sel] || longint'(time_left[i]) < res_clk)) begin
               best = longint'(time_left[i]);
               sel  = i;
               break;
            end
         end
      end
      p.found        = (sel >= 0);
      p.task_id      = (sel >= 0) ? sel[2:0] : 3'd0;
      p.time_to_next = best[31:0];
      return p;
   endfunction

   always @(posedge clock) begin
      pick_type want;
      if (reset) begin
         horizon = HORIZON_RESET;
         for (int i = 0; i < TASK_COUNT; i++) begin
            codes[i]     = 8'd0;
            reserves[i]  = 8'd0;
            latencies[i] = 8'd0;
            time_left[i] = 32'sd0;
         end
         pick_queue.delete();
         errors = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (pick_queue.size() == 0) begin
               errors++;
               $display("%0t: unexpected result, actual task %0d valid %0d time %0d",
                        $time, rsp_selected_task, rsp_task_valid, rsp_time_to_next);
            end else begin
               want = pick_queue.pop_front();
               if (rsp_selected_task !== want.task_id) begin
                  errors++;
                  $display("%0t: selected_task expected %0d actual %0d",
                           $time, want.task_id, rsp_selected_task);
               end
               if (rsp_task_valid !== want.found) begin
                  errors++;
                  $display("%0t: task_valid expected %0d actual %0d",
                           $time, want.found, rsp_task_valid);
               end
               if (rsp_time_to_next !== want.time_to_next) begin
                  errors++;
                  $display("%0t: time_to_next expected %0d actual %0d",
                           $time, want.time_to_next, rsp_time_to_next);
               end
            end
         end
         if (req_valid && req_ready) begin
            if (req_command == CMD_WRITE) begin
               if (req_slot < TASK_COUNT) begin
                  codes[req_slot]     = req_event_code;
                  reserves[req_slot]  = req_reserve;
                  latencies[req_slot] = req_latency;
                  time_left[req_slot] =
                     clamp_time(longint'(req_next_time) + longint'(req_elapsed));
               end
            end else begin
               pick_queue.push_back(pick_next_task(req_elapsed));
            end
         end
         if (csr_wr_en) begin
            horizon = csr_wr_data;
         end
      end
      pending_picks  <= pick_queue.size();
      mismatch_count <= errors;
   end

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
   import rts_pkg::*;

   localparam int ITEMS_PER_PHASE = 430;
   localparam int SETTLE_CYCLES   = 2 * TASK_COUNT + 4;
   localparam int QUIET_LIMIT     = 2000;

   typedef struct {
      logic               command;
      logic [15:0]        elapsed;
      logic [2:0]         slot;
      logic [7:0]         event_code;
      logic [7:0]         reserve;
      logic [7:0]         latency;
      logic signed [31:0] next_time;
   } sched_req_type;

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_ready;
   logic               req_command;
   logic [15:0]        req_elapsed;
   logic [2:0]         req_slot;
   logic [7:0]         req_event_code;
   logic [7:0]         req_reserve;
   logic [7:0]         req_latency;
   logic signed [31:0] req_next_time;
   logic               rsp_valid;
   logic               rsp_ready;
   logic [2:0]         rsp_selected_task;
   logic               rsp_task_valid;
   logic signed [31:0] rsp_time_to_next;
   logic               csr_wr_en;
   logic [30:0]        csr_wr_data;

   int req_idle_pct;
   int rsp_idle_pct;
   int quiet_cycles;
   int pending_picks;
   int mismatch_count;

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   reserving_task_scheduler_top u_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_command       (req_command),
      .req_elapsed       (req_elapsed),
      .req_slot          (req_slot),
      .req_event_code    (req_event_code),
      .req_reserve       (req_reserve),
      .req_latency       (req_latency),
      .req_next_time     (req_next_time),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_selected_task (rsp_selected_task),
      .rsp_task_valid    (rsp_task_valid),
      .rsp_time_to_next  (rsp_time_to_next),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data)
   );

   rts_pick_checker u_checker (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_command       (req_command),
      .req_elapsed       (req_elapsed),
      .req_slot          (req_slot),
      .req_event_code    (req_event_code),
      .req_reserve       (req_reserve),
      .req_latency       (req_latency),
      .req_next_time     (req_next_time),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_selected_task (rsp_selected_task),
      .rsp_task_valid    (rsp_task_valid),
      .rsp_time_to_next  (rsp_time_to_next),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data),
      .pending_picks     (pending_picks),
      .mismatch_count    (mismatch_count)
   );

   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(0, 99) >= rsp_idle_pct);
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("reserving_task_scheduler_top: mismatch");
         $finish;
      end
   end

   function automatic sched_req_type random_request();
      sched_req_type r;
      r.command = ($urandom_range(0, 99) < 45) ? CMD_WRITE : CMD_SCHEDULE;
      case ($urandom_range(0, 9))
         0: r.elapsed = 16'd0;
         1: r.elapsed = 16'hffff;
         2: r.elapsed = 16'($urandom);
         default: r.elapsed = 16'($urandom_range(0, 1500));
      endcase
      r.slot = 3'($urandom_range(0, 7));
      case ($urandom_range(0, 7))
         0, 1: r.event_code = 8'd0;
         2: r.event_code = 8'hff;
         default: r.event_code = 8'($urandom_range(1, 254));
      endcase
      case ($urandom_range(0, 5))
         0: r.reserve = 8'd0;
         1: r.reserve = 8'hff;
         default: r.reserve = 8'($urandom);
      endcase
      case ($urandom_range(0, 5))
         0: r.latency = 8'd0;
         1: r.latency = 8'hff;
         default: r.latency = 8'($urandom);
      endcase
      case ($urandom_range(0, 9))
         0: r.next_time = 32'sh7fff_ffff;
         1: r.next_time = 32'sh8000_0000;
         2: r.next_time = $urandom;
         3: r.next_time = int'($urandom_range(0, 400)) - 200;
         default: r.next_time = int'($urandom_range(0, 30000)) - 2000;
      endcase
      return r;
   endfunction

   task automatic send_request(input sched_req_type r);
      while ($urandom_range(0, 99) < req_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_command    <= r.command;
      req_elapsed    <= r.elapsed;
      req_slot       <= r.slot;
      req_event_code <= r.event_code;
      req_reserve    <= r.reserve;
      req_latency    <= r.latency;
      req_next_time  <= r.next_time;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic send_write(input logic [2:0] idx, input logic [7:0] code,
                             input logic [7:0] reserve, input logic [7:0] latency,
                             input logic signed [31:0] next_time,
                             input logic [15:0] elapsed);
      sched_req_type r;
      r.command    = CMD_WRITE;
      r.slot       = idx;
      r.event_code = code;
      r.reserve    = reserve;
      r.latency    = latency;
      r.next_time  = next_time;
      r.elapsed    = elapsed;
      send_request(r);
   endtask

   task automatic send_schedule(input logic [15:0] elapsed);
      sched_req_type r;
      r         = random_request();
      r.command = CMD_SCHEDULE;
      r.elapsed = elapsed;
      send_request(r);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_picks != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_horizon(input logic [30:0] value);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   task automatic run_random(input int req_pct, input int rsp_pct, input int count);
      req_idle_pct = req_pct;
      rsp_idle_pct = rsp_pct;
      repeat (count) send_request(random_request());
   endtask

   initial begin
      reset          <= 1'b1;
      req_valid      <= 1'b0;
      req_command    <= CMD_SCHEDULE;
      req_elapsed    <= 16'd0;
      req_slot       <= 3'd0;
      req_event_code <= 8'd0;
      req_reserve    <= 8'd0;
      req_latency    <= 8'd0;
      req_next_time  <= 32'sd0;
      csr_wr_en      <= 1'b0;
      csr_wr_data    <= 31'd0;
      req_idle_pct   = 29;
      rsp_idle_pct   = 50;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // empty table reports the horizon
      send_schedule(16'd0);
      send_write(3'd7, 8'hff, 8'd0, 8'hff, 32'sd1000, 16'd0);
      send_schedule(16'd0);
      // saturation on write and on aging, overdue pick
      send_write(3'd3, 8'd1, 8'hff, 8'd0, 32'sh7fff_ffff, 16'hffff);
      send_write(3'd5, 8'd2, 8'd10, 8'd200, 32'sh8000_0000, 16'd0);
      send_schedule(16'hffff);
      send_write(3'd0, 8'd3, 8'd0, 8'd0, 32'sd50, 16'd0);
      send_write(3'd2, 8'd4, 8'hff, 8'hff, 32'sd500000, 16'd0);
      send_schedule(16'd1);
      // preemption by a low-latency task
      send_write(3'd1, 8'd5, 8'd1, 8'd0, 32'sd8000, 16'd0);
      send_schedule(16'd0);
      // equal times go to the lower index
      send_write(3'd0, 8'd0, 8'd0, 8'd0, 32'sd0, 16'd0);
      send_write(3'd1, 8'd0, 8'd0, 8'd0, 32'sd0, 16'd0);
      send_write(3'd3, 8'd0, 8'd0, 8'd0, 32'sd0, 16'd0);
      send_write(3'd5, 8'd0, 8'd0, 8'd0, 32'sd0, 16'd0);
      send_write(3'd7, 8'd0, 8'd0, 8'd0, 32'sd0, 16'd0);
      send_write(3'd6, 8'd9, 8'd0, 8'hff, 32'sd20, 16'd0);
      send_write(3'd4, 8'd9, 8'd0, 8'hff, 32'sd20, 16'd0);
      send_schedule(16'd0);
      drain();

      set_horizon(31'h7fff_ffff);
      run_random(29, 50, ITEMS_PER_PHASE);
      drain();
      set_horizon(31'd0);
      run_random(50, 29, ITEMS_PER_PHASE);
      drain();
      set_horizon(31'($urandom_range(1, 100000)));
      run_random(0, 0, ITEMS_PER_PHASE);
      drain();

      if (mismatch_count == 0) begin
         $display("reserving_task_scheduler_top: match");
      end else begin
         $display("reserving_task_scheduler_top: mismatch");
      end
      $finish;
   end

endmodule
